// File: rtl/n7s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n7s_pkg
// Types, constants and the segment code table shared by the seven-segment
// digit writer.
// ----------------------------------------------------------------------------
package n7s_pkg;

	localparam int DIGITS    = 8;
	localparam int MAX_FIELD = 8;
	localparam logic [3:0] FIELD_CAP = 4'((DIGITS < MAX_FIELD) ? DIGITS : MAX_FIELD);

	localparam logic [7:0]  BLANK_CODE = 8'h80;
	localparam logic [7:0]  POINT_MASK = 8'h7F;
	// reciprocal of ten, exact for every 16-bit value with a shift of 19
	localparam logic [16:0] RECIP_TEN  = 17'd52429;
	localparam int          RECIP_SHIFT = 19;

	typedef struct packed {
		logic              op;
		logic [15:0]       value;
		logic signed [7:0] exponent;
		logic [2:0]        start_req;
		logic [3:0]        digit_count;
	} req_t;

	typedef struct packed {
		logic [3:0] position;
		logic [7:0] segments;
		logic       last;
	} digit_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       last;
		logic [3:0] count;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'h0: s = 8'hFB;
			4'h1: s = 8'hB0;
			4'h2: s = 8'hED;
			4'h3: s = 8'hF5;
			4'h4: s = 8'hB6;
			4'h5: s = 8'hD7;
			4'h6: s = 8'hDF;
			4'h7: s = 8'hF0;
			4'h8: s = 8'hFF;
			4'h9: s = 8'hF7;
			4'hA: s = 8'hFE;
			4'hB: s = 8'h9F;
			4'hC: s = 8'hCB;
			4'hD: s = 8'hBD;
			4'hE: s = 8'hCF;
			4'hF: s = 8'hCE;
			default: s = BLANK_CODE;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/n7s_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n7s_ctrl
// Request sequencer: takes a request, saturates the digit count and steps
// the datapath once per digit whenever the output register is free.
// ----------------------------------------------------------------------------
module n7s_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [3:0]        req_count,
	output logic              req_stall,
	input  n7s_pkg::status_t  status,
	output n7s_pkg::cmd_t     cmd
);
	import n7s_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [3:0] sat_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign sat_count = (req_count > FIELD_CAP) ? FIELD_CAP : req_count;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		req_stall = 1'b1;
		cmd       = '0;
		cmd.count = sat_count;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					cnt_d    = sat_count;
					if (sat_count != 4'd0)
						state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.last = (cnt_q == 4'd1);
				if (status.out_free) begin
					cmd.step = 1'b1;
					cnt_d    = cnt_q - 4'd1;
					if (cnt_q == 4'd1)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/n7s_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n7s_dp
// Digit datapath: holds the running value and exponent, extracts one digit
// per step and keeps the output register.
// ----------------------------------------------------------------------------
module n7s_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  n7s_pkg::req_t     req,
	input  n7s_pkg::cmd_t     cmd,
	output n7s_pkg::status_t  status,
	output logic              digit_valid,
	input  logic              digit_stall,
	output n7s_pkg::digit_t   digit
);
	import n7s_pkg::*;

	logic              hex_q;
	logic [15:0]       v_q;
	logic signed [8:0] e_q;
	logic              exp_nz_q;
	logic [3:0]        pos_q;
	digit_t            out_q;
	logic              out_valid_q;

	logic [32:0] prod;
	logic [15:0] quot;
	logic [15:0] rem_full;
	logic [3:0]  dig;
	logic [15:0] next_v;
	logic [7:0]  seg;

	assign prod     = 33'(v_q) * 33'(RECIP_TEN);
	assign quot     = 16'(prod[32:RECIP_SHIFT]);
	assign rem_full = v_q - ((quot << 3) + (quot << 1));
	assign dig      = hex_q ? v_q[3:0] : rem_full[3:0];
	assign next_v   = hex_q ? (v_q >> 4) : quot;

	always_comb begin
		if (v_q == 16'd0 && e_q > 9'sd0)
			seg = BLANK_CODE;
		else
			seg = seg_code(dig);
		if (e_q == 9'sd0 && exp_nz_q)
			seg = seg & POINT_MASK;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hex_q    <= req.op;
			v_q      <= req.value;
			e_q      <= {req.exponent[7], req.exponent};
			exp_nz_q <= (req.exponent != 8'sd0);
			pos_q    <= {1'b0, req.start_req} + cmd.count - 4'd1;
		end else if (cmd.step) begin
			v_q   <= next_v;
			e_q   <= e_q + 9'sd1;
			pos_q <= pos_q - 4'd1;
			out_q <= '{position: pos_q, segments: seg, last: cmd.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (!digit_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || !digit_stall;
	assign digit_valid     = out_valid_q;
	assign digit           = out_q;

endmodule

// File: rtl/number_to_seven_segment_digits_core.sv
`timescale 1ns / 1ps
// order: a taken request loads the datapath registers, then each step writes the output register
// throughput: one digit per cycle from the digit sequencer and output register
//   while digit_stall is low; a new request waits until the last digit is stepped
// reset: arst_n clears sequencer state and the output valid flag at once
// ----------------------------------------------------------------------------
// number_to_seven_segment_digits_core
// Turns a 16-bit value into a field of decimal or hex seven-segment codes,
// one digit transaction per cycle while not stalled, rightmost digit first.
// ----------------------------------------------------------------------------
module number_to_seven_segment_digits_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  n7s_pkg::req_t    req,
	output logic             digit_valid,
	input  logic             digit_stall,
	output n7s_pkg::digit_t  digit
);
	import n7s_pkg::*;

	cmd_t    cmd;
	status_t status;

	n7s_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_count (req.digit_count),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	n7s_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cmd         (cmd),
		.status      (status),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall),
		.digit       (digit)
	);

endmodule

// File: rtl/n7s_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n7s_checker
// Port-level checks of the digit writer, bound to the top level.
// ----------------------------------------------------------------------------
module n7s_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_stall,
	input logic             digit_valid,
	input logic             digit_stall,
	input n7s_pkg::digit_t  digit
);
	import n7s_pkg::*;

	// stalled digit holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && digit_stall |=> digit_valid && $stable(digit))
		else $error("stalled digit changed");

	// no new request while a field is still being written
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !digit.last |-> req_stall)
		else $error("request taken mid field");

	// next digit follows a taken non-final digit with no gap
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !digit_stall && !digit.last |=> digit_valid)
		else $error("gap inside a field");

endmodule

bind number_to_seven_segment_digits_core n7s_checker u_n7s_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_stall   (req_stall),
	.digit_valid (digit_valid),
	.digit_stall (digit_stall),
	.digit       (digit)
);

// File: sim/tb_number_to_seven_segment_digits_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_number_to_seven_segment_digits_core
// Sends display requests in both bases and checks every digit transaction
// against a local model of the digit writer, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_number_to_seven_segment_digits_core;
	import n7s_pkg::*;

	typedef enum logic {
		BASE_DEC = 1'b0,
		BASE_HEX = 1'b1
	} base_e;

	localparam logic [7:0] SEG_LUT [16] = '{
		8'hFB, 8'hB0, 8'hED, 8'hF5, 8'hB6, 8'hD7, 8'hDF, 8'hF0,
		8'hFF, 8'hF7, 8'hFE, 8'h9F, 8'hCB, 8'hBD, 8'hCF, 8'hCE
	};
	localparam int MAX_GAP = 6;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   req_valid = 1'b0;
	logic   req_stall;
	req_t   req = '0;
	logic   digit_valid;
	logic   digit_stall = 1'b0;
	digit_t digit;

	digit_t digits_due[$];
	int     mismatches = 0;
	bit     quiet_gaps = 1'b0;
	int     stall_left = 0;

	number_to_seven_segment_digits_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall),
		.digit       (digit)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int draw_gap();
		if (quiet_gaps)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// expected digit transactions of one request, rightmost digit first
	function automatic void predict_digits(input req_t r);
		int unsigned n;
		int unsigned num;
		int unsigned d;
		int          ex;
		int          e;
		logic [7:0]  seg;
		digit_t      dg;
		n = r.digit_count;
		if (n > FIELD_CAP)
			n = FIELD_CAP;
		num = r.value;
		ex = $signed(r.exponent);
		for (int unsigned k = 0; k < n; k++) begin
			e = ex + int'(k);
			d = (r.op == BASE_HEX) ? num % 16 : num % 10;
			if (num != 0 || e <= 0)
				seg = SEG_LUT[d];
			else
				seg = BLANK_CODE;
			if (e == 0 && ex != 0)
				seg = seg & POINT_MASK;
			dg.position = 4'(r.start_req + n - 1 - k);
			dg.segments = seg;
			dg.last = (k + 1 == n);
			digits_due.push_back(dg);
			num = (r.op == BASE_HEX) ? num / 16 : num / 10;
		end
	endfunction

	function automatic req_t make_req(input base_e b, input int unsigned val, input int ex,
		input int unsigned st, input int unsigned cnt);
		req_t r;
		r.op = b;
		r.value = 16'(val);
		r.exponent = 8'(ex);
		r.start_req = 3'(st);
		r.digit_count = 4'(cnt);
		return r;
	endfunction

	// called at a rising edge, returns at the edge that takes the request
	task automatic send_req(input req_t r);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		predict_digits(r);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (digit_valid === 1'b1 && digit_stall === 1'b0) begin
				if (digits_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected digit pos=%0d seg=%02h last=%0b",
							$time, digit.position, digit.segments, digit.last);
					mismatches++;
				end else begin
					if (digit.position !== digits_due[0].position ||
						digit.segments !== digits_due[0].segments ||
						digit.last !== digits_due[0].last) begin
						if (mismatches < 10)
							$display({"%0t: digit mismatch exp pos=%0d seg=%02h last=%0b",
								" got pos=%0d seg=%02h last=%0b"}, $time,
								digits_due[0].position, digits_due[0].segments,
								digits_due[0].last, digit.position, digit.segments,
								digit.last);
						mismatches++;
					end
					void'(digits_due.pop_front());
				end
				stall_left = draw_gap();
			end
			if (stall_left > 0) begin
				digit_stall <= 1'b1;
				stall_left--;
			end else begin
				digit_stall <= 1'b0;
			end
		end
	end

	task automatic test_extremes();
		send_req(make_req(BASE_DEC, 0, 0, 0, 8));
		send_req(make_req(BASE_DEC, 65535, 0, 0, 8));
		send_req(make_req(BASE_HEX, 65535, 0, 0, 8));
		send_req(make_req(BASE_HEX, 16'hABCD, 0, 4, 4));
		send_req(make_req(BASE_HEX, 16'h0123, 0, 0, 4));
		send_req(make_req(BASE_DEC, 9, 0, 5, 1));
		send_req(make_req(BASE_DEC, 7, -128, 0, 8));
		send_req(make_req(BASE_DEC, 0, 127, 7, 8));
		send_req(make_req(BASE_HEX, 65535, 127, 7, 1));
	endtask

	task automatic test_points();
		send_req(make_req(BASE_DEC, 12345, -2, 0, 8));
		send_req(make_req(BASE_DEC, 5, -3, 2, 6));
		send_req(make_req(BASE_DEC, 0, -1, 0, 3));
		send_req(make_req(BASE_HEX, 0, -1, 7, 2));
		send_req(make_req(BASE_HEX, 16'h00FF, -2, 0, 8));
		send_req(make_req(BASE_DEC, 42, 2, 0, 5));
	endtask

	task automatic test_count_limits();
		send_req(make_req(BASE_DEC, 999, 0, 3, 0));
		send_req(make_req(BASE_HEX, 65535, -1, 7, 0));
		send_req(make_req(BASE_HEX, 16'h8000, -4, 1, 15));
		send_req(make_req(BASE_DEC, 10000, 1, 0, 9));
	endtask

	task automatic test_random(input int items);
		req_t r;
		int   pick;
		for (int i = 0; i < items; i++) begin
			r.op = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 3);
			if (pick == 0)
				r.value = 16'($urandom_range(0, 99));
			else if (pick == 1)
				r.value = 16'($urandom_range(0, 4095));
			else
				r.value = 16'($urandom_range(0, 65535));
			if ($urandom_range(0, 4) == 0)
				r.exponent = 8'($urandom_range(0, 255));
			else
				r.exponent = 8'(int'($urandom_range(0, 16)) - 8);
			r.start_req = 3'($urandom_range(0, 7));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				r.digit_count = 4'd0;
			else if (pick == 1)
				r.digit_count = 4'($urandom_range(9, 15));
			else
				r.digit_count = 4'($urandom_range(1, 8));
			send_req(r);
		end
	endtask

	// hold off new requests until the output side has emptied
	task automatic test_drain();
		send_req(make_req(BASE_DEC, 31415, -4, 0, 8));
		req_valid <= 1'b0;
		while (digits_due.size() != 0)
			@(posedge clk);
		send_req(make_req(BASE_HEX, 16'hBEEF, 0, 0, 4));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_points();
		test_count_limits();
		quiet_gaps = 1'b1;
		test_random(25);
		quiet_gaps = 1'b0;
		test_random(40);
		test_drain();
		test_random(45);
		req_valid <= 1'b0;
		while (digits_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && digits_due.size() == 0)
			$display("tb_number_to_seven_segment_digits_core: PASS");
		else
			$display("tb_number_to_seven_segment_digits_core: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_number_to_seven_segment_digits_core: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/n7s_pkg.sv
rtl/n7s_ctrl.sv
rtl/n7s_dp.sv
rtl/number_to_seven_segment_digits_core.sv
rtl/n7s_checker.sv
sim/tb_number_to_seven_segment_digits_core.sv
